// ----- design/three_band_equalizer_assert.svh -----
// assertion macros shared by the equalizer modules
// depends on nothing; included by the sequencer and the datapath
`ifndef THREE_BAND_EQUALIZER_ASSERT_SVH
`define THREE_BAND_EQUALIZER_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define TBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TBE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/tbe_pkg.sv -----
// shared constants, types and the microcode table of the three-band equalizer
// depends on nothing; used by every equalizer module and interface
package tbe_pkg;

	// sample and coefficient formats
	localparam int SAMPLE_WIDTH = 24;
	localparam int COEF_WIDTH   = 16;
	localparam int GAIN_WIDTH   = 16;
	localparam int GAIN_FRAC    = 12;
	localparam int FRAC_EXT     = 8;
	localparam int POLES        = 4;
	localparam int HIST         = 3;
	localparam int SIDES        = 2;

	// datapath widths
	localparam int POLE_W    = SAMPLE_WIDTH + FRAC_EXT;
	localparam int DIFF_W    = POLE_W + 1;
	localparam int MULB_W    = ((COEF_WIDTH > GAIN_WIDTH) ? COEF_WIDTH : GAIN_WIDTH) + 1;
	localparam int PROD_W    = DIFF_W + MULB_W;
	localparam int ACC_W     = PROD_W + 2;
	localparam int OUT_SHIFT = GAIN_FRAC + FRAC_EXT;
	localparam int STAGE_W   = $clog2(POLES);
	localparam int ST_AW     = STAGE_W + 2;
	localparam int ST_DEPTH  = 2 * SIDES * POLES;
	localparam int HIST_N    = SIDES * HIST;

	// rounding offsets (half an lsb of the dropped fraction)
	localparam logic [PROD_W-1:0] COEF_HALF = PROD_W'(1) << (COEF_WIDTH - 1);
	localparam logic [ACC_W-1:0]  ACC_HALF  = ACC_W'(1) << (OUT_SHIFT - 1);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = (COEF_WIDTH > GAIN_WIDTH) ? COEF_WIDTH : GAIN_WIDTH;

	localparam logic [CFG_IDX_W-1:0] REG_EQ_ENABLE   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MONO_SOURCE = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN    = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_LOW_COEF    = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEF   = CFG_IDX_W'(6);

	localparam logic [GAIN_WIDTH-1:0] GAIN_RST      = GAIN_WIDTH'(4096);
	localparam logic [COEF_WIDTH-1:0] LOW_COEF_RST  = COEF_WIDTH'(6860);
	localparam logic [COEF_WIDTH-1:0] HIGH_COEF_RST = COEF_WIDTH'(42132);

	typedef struct packed {
		logic                  eq_enable;
		logic                  mono_source;
		logic [GAIN_WIDTH-1:0] low_gain;
		logic [GAIN_WIDTH-1:0] mid_gain;
		logic [GAIN_WIDTH-1:0] high_gain;
		logic [COEF_WIDTH-1:0] low_coef;
		logic [COEF_WIDTH-1:0] high_coef;
	} cfg_t;

	// sequencer jump conditions
	localparam int JC_W = 3;
	localparam logic [JC_W-1:0] JC_NEXT = 3'd0;  // fall through
	localparam logic [JC_W-1:0] JC_WAIT = 3'd1;  // hold until a frame transfer
	localparam logic [JC_W-1:0] JC_BYP  = 3'd2;  // jump when frame bypasses
	localparam logic [JC_W-1:0] JC_SIDE = 3'd3;  // jump back for the right side
	localparam logic [JC_W-1:0] JC_OUT  = 3'd4;  // hold until output free, then jump
	localparam logic [JC_W-1:0] JC_JUMP = 3'd5;  // unconditional

	// multiplier operand select
	localparam logic [1:0] MS_POLE = 2'd0;
	localparam logic [1:0] MS_LOW  = 2'd1;
	localparam logic [1:0] MS_MID  = 2'd2;
	localparam logic [1:0] MS_HIGH = 2'd3;

	// accumulator operation
	localparam logic [1:0] ACC_HOLD = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	// program steps
	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] PC_IDLE  = 5'd0;
	localparam logic [PC_W-1:0] PC_START = 5'd1;
	localparam logic [PC_W-1:0] PC_L0M   = 5'd2;
	localparam logic [PC_W-1:0] PC_L0U   = 5'd3;
	localparam logic [PC_W-1:0] PC_L1M   = 5'd4;
	localparam logic [PC_W-1:0] PC_L1U   = 5'd5;
	localparam logic [PC_W-1:0] PC_L2M   = 5'd6;
	localparam logic [PC_W-1:0] PC_L2U   = 5'd7;
	localparam logic [PC_W-1:0] PC_L3M   = 5'd8;
	localparam logic [PC_W-1:0] PC_L3U   = 5'd9;
	localparam logic [PC_W-1:0] PC_XH    = 5'd10;
	localparam logic [PC_W-1:0] PC_H0M   = 5'd11;
	localparam logic [PC_W-1:0] PC_H0U   = 5'd12;
	localparam logic [PC_W-1:0] PC_H1M   = 5'd13;
	localparam logic [PC_W-1:0] PC_H1U   = 5'd14;
	localparam logic [PC_W-1:0] PC_H2M   = 5'd15;
	localparam logic [PC_W-1:0] PC_H2U   = 5'd16;
	localparam logic [PC_W-1:0] PC_H3M   = 5'd17;
	localparam logic [PC_W-1:0] PC_H3U   = 5'd18;
	localparam logic [PC_W-1:0] PC_MLO   = 5'd19;
	localparam logic [PC_W-1:0] PC_MMID  = 5'd20;
	localparam logic [PC_W-1:0] PC_MHI   = 5'd21;
	localparam logic [PC_W-1:0] PC_ACC   = 5'd22;
	localparam logic [PC_W-1:0] PC_FIN   = 5'd23;
	localparam logic [PC_W-1:0] PC_OUT   = 5'd24;

	// one control word
	typedef struct packed {
		logic [JC_W-1:0]    jc;
		logic [PC_W-1:0]    tgt;
		logic               x_load;
		logic               lb_save;
		logic               mul_en;
		logic [1:0]         mul_sel;
		logic               cascade;
		logic [STAGE_W-1:0] stage;
		logic               pole_upd;
		logic [1:0]         acc_op;
		logic               hist_shift;
	} uword_t;

	// sequencer to datapath
	typedef struct packed {
		uword_t uw;
		logic   side;
		logic   idle;
		logic   res_save;
		logic   out_load;
	} ctrl_t;

	// datapath to sequencer
	typedef struct packed {
		logic accept;
		logic byp;
		logic out_busy;
	} status_t;

	// multiply or update step of one pole
	function automatic uword_t pole_word(input logic casc, input logic [STAGE_W-1:0] stg,
		input logic upd);
		uword_t w;
		w = '0;
		w.jc = JC_NEXT;
		w.cascade = casc;
		w.stage = stg;
		w.mul_en = ~upd;
		w.mul_sel = MS_POLE;
		w.pole_upd = upd;
		return w;
	endfunction

	// microcode rom
	function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '0;
		w.jc = JC_NEXT;
		case (pc)
			PC_IDLE: w.jc = JC_WAIT;
			PC_START: begin
				w.jc = JC_BYP;
				w.tgt = PC_OUT;
				w.x_load = 1'b1;
			end
			PC_L0M: w = pole_word(1'b0, STAGE_W'(0), 1'b0);
			PC_L0U: w = pole_word(1'b0, STAGE_W'(0), 1'b1);
			PC_L1M: w = pole_word(1'b0, STAGE_W'(1), 1'b0);
			PC_L1U: w = pole_word(1'b0, STAGE_W'(1), 1'b1);
			PC_L2M: w = pole_word(1'b0, STAGE_W'(2), 1'b0);
			PC_L2U: w = pole_word(1'b0, STAGE_W'(2), 1'b1);
			PC_L3M: w = pole_word(1'b0, STAGE_W'(3), 1'b0);
			PC_L3U: w = pole_word(1'b0, STAGE_W'(3), 1'b1);
			PC_XH: begin
				w.x_load = 1'b1;
				w.lb_save = 1'b1;
			end
			PC_H0M: w = pole_word(1'b1, STAGE_W'(0), 1'b0);
			PC_H0U: w = pole_word(1'b1, STAGE_W'(0), 1'b1);
			PC_H1M: w = pole_word(1'b1, STAGE_W'(1), 1'b0);
			PC_H1U: w = pole_word(1'b1, STAGE_W'(1), 1'b1);
			PC_H2M: w = pole_word(1'b1, STAGE_W'(2), 1'b0);
			PC_H2U: w = pole_word(1'b1, STAGE_W'(2), 1'b1);
			PC_H3M: w = pole_word(1'b1, STAGE_W'(3), 1'b0);
			PC_H3U: w = pole_word(1'b1, STAGE_W'(3), 1'b1);
			PC_MLO: begin
				w.mul_en = 1'b1;
				w.mul_sel = MS_LOW;
			end
			PC_MMID: begin
				w.mul_en = 1'b1;
				w.mul_sel = MS_MID;
				w.acc_op = ACC_LOAD;
			end
			PC_MHI: begin
				w.mul_en = 1'b1;
				w.mul_sel = MS_HIGH;
				w.acc_op = ACC_ADD;
			end
			PC_ACC: begin
				w.acc_op = ACC_ADD;
				w.hist_shift = 1'b1;
			end
			PC_FIN: begin
				w.jc = JC_SIDE;
				w.tgt = PC_START;
			end
			PC_OUT: begin
				w.jc = JC_OUT;
				w.tgt = PC_IDLE;
			end
			default: begin
				w.jc = JC_JUMP;
				w.tgt = PC_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- design/tbe_if.sv -----
// valid/ready channel interfaces for equalizer input and output frames
// depends on tbe_pkg for the sample width
interface tbe_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [tbe_pkg::SAMPLE_WIDTH-1:0] left_in;
	logic signed [tbe_pkg::SAMPLE_WIDTH-1:0] right_in;

	modport source (output valid, left_in, right_in, input ready);
	modport sink (input valid, left_in, right_in, output ready);
endinterface

interface tbe_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [tbe_pkg::SAMPLE_WIDTH-1:0] left_out;
	logic signed [tbe_pkg::SAMPLE_WIDTH-1:0] right_out;

	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

// ----- design/tbe_seq.sv -----
// microcode sequencer: step counter, control rom lookup and conditional jumps
// depends on tbe_pkg and three_band_equalizer_assert.svh
`include "three_band_equalizer_assert.svh"

module tbe_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  tbe_pkg::status_t status,
	output tbe_pkg::ctrl_t   ctrl
);
	import tbe_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic [PC_W-1:0] pc_inc;
	logic            side_q;
	logic            res_save;
	logic            out_load;
	uword_t          uw;

	// current control word
	assign uw = ucode_rom(pc_q);
	assign pc_inc = pc_q + PC_W'(1);

	// next step
	always_comb begin
		pc_d = pc_inc;
		case (uw.jc)
			JC_NEXT: pc_d = pc_inc;
			JC_WAIT: pc_d = status.accept ? pc_inc : pc_q;
			JC_BYP:  pc_d = status.byp ? uw.tgt : pc_inc;
			JC_SIDE: pc_d = side_q ? pc_inc : uw.tgt;
			JC_OUT:  pc_d = status.out_busy ? pc_q : uw.tgt;
			JC_JUMP: pc_d = uw.tgt;
			default: pc_d = PC_IDLE;
		endcase
	end

	// left result parks and right side starts; output loads once free
	assign res_save = (uw.jc == JC_SIDE) && !side_q;
	assign out_load = (uw.jc == JC_OUT) && !status.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
			side_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (status.accept) begin
				side_q <= 1'b0;
			end else if (res_save) begin
				side_q <= 1'b1;
			end
		end
	end

	assign ctrl.uw = uw;
	assign ctrl.side = side_q;
	assign ctrl.idle = (pc_q == PC_IDLE);
	assign ctrl.res_save = res_save;
	assign ctrl.out_load = out_load;

	`TBE_ASSERT_IMP(a_pc_range, clk, arst_n, 1'b1, pc_q <= PC_OUT, "step counter out of program")
	`TBE_ASSERT_NXT(a_accept_start, clk, arst_n, status.accept, pc_q == PC_START, "no start after transfer")
	`TBE_ASSERT_NXT(a_side_switch, clk, arst_n, res_save, side_q && pc_q == PC_START, "right side not started")

endmodule

// ----- design/tbe_dp.sv -----
// datapath: pole and history state, shared multiplier, accumulator, output register
// depends on tbe_pkg, tbe_if and three_band_equalizer_assert.svh
`include "three_band_equalizer_assert.svh"

module tbe_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  tbe_pkg::ctrl_t   ctrl,
	input  tbe_pkg::cfg_t    cfg,
	tbe_in_if.sink           dry,
	tbe_out_if.source        wet,
	output tbe_pkg::status_t status
);
	import tbe_pkg::*;

	logic signed [SAMPLE_WIDTH-1:0] in_l_q;
	logic signed [SAMPLE_WIDTH-1:0] in_r_q;
	logic                           byp_q;
	logic signed [POLE_W-1:0]       st_q [ST_DEPTH];
	logic signed [SAMPLE_WIDTH-1:0] hist_q [HIST_N];
	logic signed [POLE_W-1:0]       x_q;
	logic signed [POLE_W-1:0]       lb_q;
	logic signed [PROD_W-1:0]       p_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [SAMPLE_WIDTH-1:0] res_l_q;
	logic signed [SAMPLE_WIDTH-1:0] left_q;
	logic signed [SAMPLE_WIDTH-1:0] right_q;
	logic                           out_valid_q;

	logic                           accept;
	logic [ST_AW-1:0]               st_addr;
	logic signed [POLE_W-1:0]       st_rd;
	logic signed [SAMPLE_WIDTH-1:0] samp;
	logic signed [POLE_W-1:0]       samp_ext;
	logic signed [SAMPLE_WIDTH-1:0] delayed;
	logic signed [POLE_W-1:0]       delayed_ext;
	logic signed [DIFF_W-1:0]       pole_d;
	logic signed [DIFF_W-1:0]       mb;
	logic signed [DIFF_W-1:0]       hb;
	logic signed [DIFF_W-1:0]       mul_a;
	logic signed [MULB_W-1:0]       mul_b;
	logic signed [PROD_W-1:0]       prod;
	logic [PROD_W-1:0]              p_bias;
	logic signed [PROD_W-1:0]       p_rnd;
	logic signed [POLE_W-1:0]       pole_inc;
	logic signed [POLE_W-1:0]       pole_new;
	logic [ACC_W-1:0]               a_bias;
	logic signed [ACC_W-1:0]        a_rnd;
	logic signed [ACC_W-1:0]        y_full;
	logic                           y_ovf;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;

	// input transfer
	assign dry.ready = ctrl.idle;
	assign accept = dry.valid && dry.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (accept) begin
			byp_q <= ~cfg.eq_enable;
		end
	end

	// mono applies only while the equalizer runs
	always_ff @(posedge clk) begin
		if (accept) begin
			in_l_q <= dry.left_in;
			in_r_q <= (cfg.eq_enable && cfg.mono_source) ? dry.left_in : dry.right_in;
		end
	end

	// operand selection for the current side
	assign samp = ctrl.side ? in_r_q : in_l_q;
	assign samp_ext = {samp, {FRAC_EXT{1'b0}}};
	assign delayed = ctrl.side ? hist_q[2 * HIST - 1] : hist_q[HIST - 1];
	assign delayed_ext = {delayed, {FRAC_EXT{1'b0}}};
	assign st_addr = {ctrl.uw.cascade, ctrl.side, ctrl.uw.stage};
	assign st_rd = st_q[st_addr];

	assign pole_d = DIFF_W'(x_q) - DIFF_W'(st_rd);
	assign mb = DIFF_W'(x_q) - DIFF_W'(lb_q);
	assign hb = DIFF_W'(delayed_ext) - DIFF_W'(x_q);

	always_comb begin
		mul_a = pole_d;
		mul_b = ctrl.uw.cascade ? MULB_W'(cfg.high_coef) : MULB_W'(cfg.low_coef);
		case (ctrl.uw.mul_sel)
			MS_POLE: begin
				mul_a = pole_d;
				mul_b = ctrl.uw.cascade ? MULB_W'(cfg.high_coef) : MULB_W'(cfg.low_coef);
			end
			MS_LOW: begin
				mul_a = DIFF_W'(lb_q);
				mul_b = MULB_W'(cfg.low_gain);
			end
			MS_MID: begin
				mul_a = mb;
				mul_b = MULB_W'(cfg.mid_gain);
			end
			MS_HIGH: begin
				mul_a = hb;
				mul_b = MULB_W'(cfg.high_gain);
			end
			default: begin
				mul_a = pole_d;
				mul_b = MULB_W'(cfg.low_coef);
			end
		endcase
	end

	// shared multiplier, registered
	assign prod = mul_a * mul_b;

	// pole update: round to nearest, ties away from zero
	assign p_bias = p_q[PROD_W-1] ? (COEF_HALF - PROD_W'(1)) : COEF_HALF;
	assign p_rnd = p_q + $signed(p_bias);
	assign pole_inc = POLE_W'(p_rnd >>> COEF_WIDTH);
	assign pole_new = st_rd + pole_inc;

	// band sum rounding and saturation
	assign a_bias = acc_q[ACC_W-1] ? (ACC_HALF - ACC_W'(1)) : ACC_HALF;
	assign a_rnd = acc_q + $signed(a_bias);
	assign y_full = a_rnd >>> OUT_SHIFT;
	assign y_ovf = !((&y_full[ACC_W-1:SAMPLE_WIDTH-1]) || !(|y_full[ACC_W-1:SAMPLE_WIDTH-1]));
	assign y_sat = y_ovf ? {y_full[ACC_W-1], {(SAMPLE_WIDTH-1){~y_full[ACC_W-1]}}}
		: y_full[SAMPLE_WIDTH-1:0];

	// filter state and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ST_DEPTH; i++) begin
				st_q[i] <= '0;
			end
			for (int i = 0; i < HIST_N; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (ctrl.uw.pole_upd) begin
				st_q[st_addr] <= pole_new;
			end
			if (ctrl.uw.hist_shift) begin
				for (int s = 0; s < SIDES; s++) begin
					if (ctrl.side == s[0]) begin
						for (int k = HIST - 1; k > 0; k--) begin
							hist_q[s * HIST + k] <= hist_q[s * HIST + k - 1];
						end
						hist_q[s * HIST] <= samp;
					end
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (ctrl.uw.x_load) begin
			x_q <= samp_ext;
		end else if (ctrl.uw.pole_upd) begin
			x_q <= pole_new;
		end
		if (ctrl.uw.lb_save) begin
			lb_q <= x_q;
		end
		if (ctrl.uw.mul_en) begin
			p_q <= prod;
		end
		case (ctrl.uw.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(p_q);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(p_q);
			default:  acc_q <= acc_q;
		endcase
		if (ctrl.res_save) begin
			res_l_q <= y_sat;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (wet.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			left_q <= byp_q ? in_l_q : res_l_q;
			right_q <= byp_q ? in_r_q : y_sat;
		end
	end

	assign wet.valid = out_valid_q;
	assign wet.left_out = left_q;
	assign wet.right_out = right_q;

	assign status.accept = accept;
	assign status.byp = byp_q;
	assign status.out_busy = out_valid_q && !wet.ready;

	`TBE_ASSERT_IMP(a_load_free, clk, arst_n, ctrl.out_load, !(out_valid_q && !wet.ready), "output overwritten")
	`TBE_ASSERT_IMP(a_upd_after_mul, clk, arst_n, ctrl.uw.pole_upd, $past(ctrl.uw.mul_en) && $past(ctrl.uw.mul_sel) == MS_POLE, "pole update without product")
	`TBE_ASSERT_IMP(a_byp_no_state, clk, arst_n, byp_q && !ctrl.idle, !ctrl.uw.pole_upd && !ctrl.uw.hist_shift, "bypass frame touched state")

endmodule

// ----- design/three_band_equalizer.sv -----
// Stereo three-band equalizer, one frame in and one frame out per transfer.
// Enabled: the left side and then the right side run through the filter program;
// every multiply goes through the single shared multiplier, stepped by the microcode.
// Disabled: samples pass unfiltered. Either way a new frame is taken only at idle.
// A stalled output holds the program at its last step until the result is taken.
// Reset (arst_n low) clears all filter state, history and output valid; restores defaults.
module three_band_equalizer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [tbe_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [tbe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	tbe_in_if.sink                            dry,
	tbe_out_if.source                         wet
);
	import tbe_pkg::*;

	cfg_t    cfg_q;
	ctrl_t   ctrl;
	status_t status;

	// configuration registers; writes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.eq_enable <= 1'b0;
			cfg_q.mono_source <= 1'b0;
			cfg_q.low_gain <= GAIN_RST;
			cfg_q.mid_gain <= GAIN_RST;
			cfg_q.high_gain <= GAIN_RST;
			cfg_q.low_coef <= LOW_COEF_RST;
			cfg_q.high_coef <= HIGH_COEF_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx)
				REG_EQ_ENABLE:   cfg_q.eq_enable <= cfg_wdata[0];
				REG_MONO_SOURCE: cfg_q.mono_source <= cfg_wdata[0];
				REG_LOW_GAIN:    cfg_q.low_gain <= cfg_wdata[GAIN_WIDTH-1:0];
				REG_MID_GAIN:    cfg_q.mid_gain <= cfg_wdata[GAIN_WIDTH-1:0];
				REG_HIGH_GAIN:   cfg_q.high_gain <= cfg_wdata[GAIN_WIDTH-1:0];
				REG_LOW_COEF:    cfg_q.low_coef <= cfg_wdata[COEF_WIDTH-1:0];
				REG_HIGH_COEF:   cfg_q.high_coef <= cfg_wdata[COEF_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	// program sequencer
	tbe_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// datapath
	tbe_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cfg    (cfg_q),
		.dry    (dry),
		.wet    (wet),
		.status (status)
	);

endmodule
